// ----- rtl/core/mahf_pkg.sv -----
// Shared types and constants for the multichannel ADC hysteresis filter.
// Used by mahf_div, mahf_store and the top level; depends on nothing.

package mahf_pkg;

  localparam int CH_W   = 6;   // channel field width
  localparam int SMP_W  = 12;  // raw sample width
  localparam int FILT_W = 16;  // filtered value width
  localparam int MUL_W  = 8;   // scale multiplier width
  localparam int CFG_W  = 12;  // configuration data width
  localparam int CFG_IDX_W = 3;

  // Divider: numerator is a 12 x 8 bit product, denominator a 12 bit register.
  localparam int DIV_NUM_W = SMP_W + MUL_W;
  localparam int DIV_DEN_W = 12;
  localparam int DIV_CNT_W = $clog2(DIV_NUM_W);

  typedef enum logic [1:0] {
    OP_SAMPLE = 2'd0,
    OP_CLEAR  = 2'd1,
    OP_READ   = 2'd2
  } op_t;

  localparam logic [CFG_IDX_W-1:0] CFG_MIN_VALUE  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_VALUE  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_NOM_STEP   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SCALE_MUL  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_SCALE_DIV  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_FIRST_CH   = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_LAST_CH    = 3'd6;

  localparam logic [SMP_W-1:0] MIN_VALUE_RST = 12'd0;
  localparam logic [SMP_W-1:0] MAX_VALUE_RST = 12'd4095;
  localparam logic [SMP_W-1:0] NOM_STEP_RST  = 12'd32;
  localparam logic [MUL_W-1:0] SCALE_MUL_RST = 8'd1;
  localparam logic [DIV_DEN_W-1:0] SCALE_DIV_RST = 12'd32;
  localparam logic [CH_W-1:0]  FIRST_CH_RST  = 6'd16;
  localparam logic [CH_W-1:0]  LAST_CH_RST   = 6'd34;

  // One channel's stored state.
  typedef struct packed {
    logic              flag;
    logic [SMP_W-1:0]  raw;
    logic [FILT_W-1:0] filt;
  } entry_t;

  // Request to the channel store; reads and writes never share a cycle.
  typedef struct packed {
    logic            rd_en;
    logic            wr_en;
    logic [CH_W-1:0] addr;
    entry_t          wdata;
  } mem_req_t;

endpackage

// ----- rtl/core/mahf_div.sv -----
// Restoring divider, one quotient bit per cycle.
// Uses mahf_pkg for widths. A zero denominator yields an all-ones quotient.

module mahf_div (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start,
  input  logic [mahf_pkg::DIV_NUM_W-1:0]      num,
  input  logic [mahf_pkg::DIV_DEN_W-1:0]      den,
  output logic                                done,
  output logic [mahf_pkg::DIV_NUM_W-1:0]      quot
);

  localparam int NW = mahf_pkg::DIV_NUM_W;
  localparam int DW = mahf_pkg::DIV_DEN_W;
  localparam int CW = mahf_pkg::DIV_CNT_W;

  logic          busy_r;
  logic          done_r;
  logic [CW-1:0] cnt_r;
  logic [NW-1:0] nq_r;
  logic [DW-1:0] rem_r;
  logic [DW-1:0] den_r;

  logic [DW:0]   trial;
  logic          ge;
  logic [DW-1:0] rem_nxt;

  always_comb begin
    trial   = {rem_r, nq_r[NW-1]};
    ge      = (trial >= {1'b0, den_r});
    rem_nxt = ge ? DW'(trial - {1'b0, den_r}) : trial[DW-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= CW'(cnt_r + 1'b1);
        if (cnt_r == CW'(NW - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      nq_r  <= num;
      rem_r <= '0;
      den_r <= den;
    end else if (busy_r) begin
      nq_r  <= {nq_r[NW-2:0], ge};
      rem_r <= rem_nxt;
    end
  end

  assign done = done_r;
  assign quot = nq_r;

endmodule

// ----- rtl/core/mahf_store.sv -----
// Per-channel state memory: one synchronous-read array plus a valid bit per
// entry so that entries never written read as zero. Uses mahf_pkg types.

module mahf_store #(
  parameter int CHANNELS = 64
) (
  input  logic               clk,
  input  logic               rst_n,
  input  mahf_pkg::mem_req_t req,
  output mahf_pkg::entry_t   rdata
);

  localparam int AW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

  mahf_pkg::entry_t mem [CHANNELS];
  logic [CHANNELS-1:0] valid_r;
  mahf_pkg::entry_t    rd_data_r;
  logic                rd_valid_r;
  logic [AW-1:0]       idx;

  assign idx = req.addr[AW-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else if (req.wr_en) begin
      valid_r[idx] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[idx] <= req.wdata;
    end
    if (req.rd_en) begin
      rd_data_r  <= mem[idx];
      rd_valid_r <= valid_r[idx];
    end
  end

  assign rdata = rd_valid_r ? rd_data_r : '0;

endmodule

// ----- rtl/core/multichannel_adc_hysteresis_filter.sv -----
// Per-channel dead-band filter with sticky change flags. Each transaction on
// the input returns exactly one result transaction. Reads, flag clears and
// samples that are not filtered go from acceptance through the lookup state
// to the result register; a filtered sample also passes the 20-step serial
// divider that forms the scaled or quantised value. One item is in flight at
// a time, but a new item is accepted while a finished result waits on the
// output. Channel state lives in one synchronous memory whose entries read as
// zero until written, so the block is ready straight after reset.

module multichannel_adc_hysteresis_filter #(
  parameter int CHANNELS = 64
) (
  input  logic        clk,
  input  logic        rst_n,
  // Input stream
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [23:0] in_tdata,   // [5:0] channel, [17:6] sample, rest zero
  input  logic [1:0]  in_tuser,   // [1:0] opcode
  // Result stream
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // [15:0] filtered_value, [27:16] raw_value,
                                  // [28] change_flag, rest zero
  // Configuration writes
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [11:0] cfg_data
);

  localparam int CH_W   = mahf_pkg::CH_W;
  localparam int SMP_W  = mahf_pkg::SMP_W;
  localparam int FILT_W = mahf_pkg::FILT_W;
  localparam int MUL_W  = mahf_pkg::MUL_W;
  localparam int NW     = mahf_pkg::DIV_NUM_W;
  localparam int DW     = mahf_pkg::DIV_DEN_W;

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_LOOK  = 5'b00010,
    S_START = 5'b00100,
    S_DIV   = 5'b01000,
    S_PUSH  = 5'b10000
  } state_t;

  // Configuration registers
  logic [SMP_W-1:0] min_value_r;
  logic [SMP_W-1:0] max_value_r;
  logic [SMP_W-1:0] nom_step_r;
  logic [MUL_W-1:0] scale_mul_r;
  logic [DW-1:0]    scale_div_r;
  logic [CH_W-1:0]  first_ch_r;
  logic [CH_W-1:0]  last_ch_r;

  state_t            state_r;
  mahf_pkg::op_t     op_r;
  logic [CH_W-1:0]   ch_r;
  logic [SMP_W-1:0]  smp_r;
  logic              oob_r;
  mahf_pkg::entry_t  ent_r;
  mahf_pkg::entry_t  res_r;
  logic              wr_need_r;
  logic              mid_r;
  logic [NW-1:0]     num_r;
  logic [DW-1:0]     den_r;
  logic              out_valid_r;
  mahf_pkg::entry_t  out_data_r;

  mahf_pkg::mem_req_t mem_req;
  mahf_pkg::entry_t   rdata;
  logic               div_done;
  logic [NW-1:0]      div_quot;

  logic                in_acc;
  logic                out_free;
  logic [SMP_W-2:0]    half;
  logic [SMP_W-3:0]    quarter;
  logic [SMP_W:0]      smp_plus_half;
  logic [SMP_W:0]      min_plus_half;
  logic                mid_band;
  logic [SMP_W-1:0]    diff;
  logic                accept_smp;
  logic                in_range;
  logic [SMP_W-1:0]    smp_off;
  logic [NW-1:0]       prod;
  logic [FILT_W-1:0]   new_filt;

  assign in_acc    = in_tvalid && in_tready;
  assign in_tready = (state_r == S_IDLE);
  assign cfg_ready = 1'b1;
  assign out_free  = !out_valid_r || out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_value_r <= mahf_pkg::MIN_VALUE_RST;
      max_value_r <= mahf_pkg::MAX_VALUE_RST;
      nom_step_r  <= mahf_pkg::NOM_STEP_RST;
      scale_mul_r <= mahf_pkg::SCALE_MUL_RST;
      scale_div_r <= mahf_pkg::SCALE_DIV_RST;
      first_ch_r  <= mahf_pkg::FIRST_CH_RST;
      last_ch_r   <= mahf_pkg::LAST_CH_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        mahf_pkg::CFG_MIN_VALUE: min_value_r <= cfg_data;
        mahf_pkg::CFG_MAX_VALUE: max_value_r <= cfg_data;
        mahf_pkg::CFG_NOM_STEP:  nom_step_r  <= cfg_data;
        mahf_pkg::CFG_SCALE_MUL: scale_mul_r <= cfg_data[MUL_W-1:0];
        mahf_pkg::CFG_SCALE_DIV: scale_div_r <= cfg_data;
        mahf_pkg::CFG_FIRST_CH:  first_ch_r  <= cfg_data[CH_W-1:0];
        mahf_pkg::CFG_LAST_CH:   last_ch_r   <= cfg_data[CH_W-1:0];
        default: ;
      endcase
    end
  end

  // Filter decision, evaluated on the entry just read from the store.
  // The mid band test s < max - half && s > min + half is rearranged so
  // that every term stays non-negative.
  always_comb begin
    half          = nom_step_r[SMP_W-1:1];
    quarter       = nom_step_r[SMP_W-1:2];
    smp_plus_half = {1'b0, smp_r} + {2'b00, half};
    min_plus_half = {1'b0, min_value_r} + {2'b00, half};
    mid_band      = (smp_plus_half < {1'b0, max_value_r}) &&
                    ({1'b0, smp_r} > min_plus_half);
    diff          = (smp_r >= rdata.raw) ? SMP_W'(smp_r - rdata.raw)
                                         : SMP_W'(rdata.raw - smp_r);
    accept_smp    = mid_band ? (diff >= {1'b0, half}) : (diff >= {2'b00, quarter});
    in_range      = (ch_r >= first_ch_r) && (ch_r <= last_ch_r);
    smp_off       = SMP_W'(smp_r - {1'b0, half});
    prod          = NW'(smp_off) * NW'(scale_mul_r);
    new_filt      = mid_r ? FILT_W'(div_quot[FILT_W-1:0] + 1'b1)
                          : div_quot[FILT_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      if (state_r == S_PUSH && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && out_tready) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (in_acc) begin
            state_r <= S_LOOK;
          end
        end
        S_LOOK: begin
          if (!oob_r && op_r == mahf_pkg::OP_SAMPLE && !rdata.flag && in_range &&
              accept_smp) begin
            state_r <= S_START;
          end else begin
            state_r <= S_PUSH;
          end
        end
        S_START: state_r <= S_DIV;
        S_DIV: begin
          if (div_done) begin
            state_r <= S_PUSH;
          end
        end
        S_PUSH: begin
          if (out_free) begin
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          op_r  <= mahf_pkg::op_t'(in_tuser);
          ch_r  <= in_tdata[CH_W-1:0];
          smp_r <= in_tdata[CH_W +: SMP_W];
          oob_r <= ({1'b0, in_tdata[CH_W-1:0]} >= (CH_W + 1)'(CHANNELS));
        end
      end
      S_LOOK: begin
        ent_r     <= rdata;
        mid_r     <= mid_band;
        num_r     <= mid_band ? prod : NW'(smp_r);
        den_r     <= mid_band ? scale_div_r : nom_step_r;
        wr_need_r <= !oob_r && (op_r == mahf_pkg::OP_CLEAR);
        if (oob_r) begin
          res_r <= '0;
        end else if (op_r == mahf_pkg::OP_CLEAR) begin
          res_r <= {1'b0, rdata.raw, rdata.filt};
        end else begin
          res_r <= rdata;
        end
      end
      S_DIV: begin
        if (div_done) begin
          res_r     <= {(new_filt != ent_r.filt), smp_r, new_filt};
          wr_need_r <= 1'b1;
        end
      end
      S_PUSH: begin
        if (out_free) begin
          out_data_r <= res_r;
        end
      end
      default: ;
    endcase
  end

  // The write back coincides with the result load, so the next item's read
  // is always issued after it.
  always_comb begin
    mem_req.rd_en = in_acc;
    mem_req.wr_en = (state_r == S_PUSH) && out_free && wr_need_r;
    mem_req.addr  = (state_r == S_IDLE) ? in_tdata[CH_W-1:0] : ch_r;
    mem_req.wdata = res_r;
  end

  mahf_store #(
    .CHANNELS(CHANNELS)
  ) u_store (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (mem_req),
    .rdata (rdata)
  );

  mahf_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (state_r == S_START),
    .num   (num_r),
    .den   (den_r),
    .done  (div_done),
    .quot  (div_quot)
  );

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {3'b000, out_data_r.flag, out_data_r.raw, out_data_r.filt};

  // A quotient must only arrive while the sequencer waits for it.
  a_div_done_in_div: assert property (@(posedge clk) disable iff (!rst_n)
    div_done |-> state_r == S_DIV)
    else $error("divider finished outside the divide state");

  // Store writes and new transactions never overlap.
  a_no_wr_on_accept: assert property (@(posedge clk) disable iff (!rst_n)
    mem_req.wr_en |-> !in_acc)
    else $error("store write coincides with an input transaction");

  // Every accepted transaction is followed by a store lookup.
  a_accept_then_look: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> state_r == S_LOOK)
    else $error("accepted transaction did not reach the lookup state");

  // A result appears only when the sequencer hands one over.
  a_result_from_push: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == S_PUSH))
    else $error("result raised without a hand-over");

  // An out-of-range channel never writes the store.
  a_oob_no_write: assert property (@(posedge clk) disable iff (!rst_n)
    (mem_req.wr_en && state_r == S_PUSH) |-> !oob_r)
    else $error("store written for a channel beyond the store depth");

endmodule

// ----- tb/sv/tb.sv -----
// Self-checking testbench for the multichannel ADC hysteresis filter.
// Depends on mahf_pkg and the multichannel_adc_hysteresis_filter top level only.
`timescale 1ns / 100ps

module tb;

  localparam int CH_W      = mahf_pkg::CH_W;
  localparam int SMP_W     = mahf_pkg::SMP_W;
  localparam int FILT_W    = mahf_pkg::FILT_W;
  localparam int MUL_W     = mahf_pkg::MUL_W;
  localparam int DIV_DEN_W = mahf_pkg::DIV_DEN_W;
  localparam int CFG_IDX_W = mahf_pkg::CFG_IDX_W;

  localparam int NUM_CH = 64;
  localparam int CYCLE_LIMIT = 2_500_000;
  localparam int DRAIN_CYCLES = 40;
  localparam int RAND_PHASES = 8;
  localparam int RAND_PER_PHASE = 232;
  localparam int MAX_REPORTED = 10;
  // The opcode field allows a fourth code, which the block treats as a read.
  localparam logic [1:0] OP_RSVD = 2'd3;
  // Register index with no register behind it.
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 3'd7;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [23:0] in_tdata = '0;    // [5:0] channel, [17:6] sample, rest zero
  logic [1:0]  in_tuser = '0;    // [1:0] opcode
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [31:0] out_tdata;        // [15:0] filtered, [27:16] raw, [28] flag, rest zero
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [2:0]  cfg_index = '0;
  logic [11:0] cfg_data = '0;

  // Shadow copy of the configuration registers.
  logic [SMP_W-1:0]     min_lvl  = mahf_pkg::MIN_VALUE_RST;
  logic [SMP_W-1:0]     max_lvl  = mahf_pkg::MAX_VALUE_RST;
  logic [SMP_W-1:0]     step_sz  = mahf_pkg::NOM_STEP_RST;
  logic [MUL_W-1:0]     mul_k    = mahf_pkg::SCALE_MUL_RST;
  logic [DIV_DEN_W-1:0] div_k    = mahf_pkg::SCALE_DIV_RST;
  logic [CH_W-1:0]      first_ch = mahf_pkg::FIRST_CH_RST;
  logic [CH_W-1:0]      last_ch  = mahf_pkg::LAST_CH_RST;

  // Per-channel state as the block should hold it.
  logic [FILT_W-1:0] chan_filt [NUM_CH] = '{default: '0};
  logic [SMP_W-1:0]  chan_raw  [NUM_CH] = '{default: '0};
  logic              chan_flag [NUM_CH] = '{default: 1'b0};

  mahf_pkg::entry_t channel_reports [$];

  int  fail_count = 0;
  int  cycle_count = 0;
  int  hold_cycles = 0;
  bit  in_burst = 1'b0;
  bit  out_burst = 1'b0;

  multichannel_adc_hysteresis_filter #(.CHANNELS(NUM_CH)) u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 75) return $urandom_range(1, 3);
    if (r < 95) return $urandom_range(4, 20);
    return $urandom_range(21, 120);
  endfunction

  // A zero divisor yields an all-ones quotient.
  function automatic logic [31:0] quot_or_ones(logic [31:0] num, logic [31:0] den);
    if (den == 0) return 32'hFFFF_FFFF;
    return num / den;
  endfunction

  // Applies one transaction to the channel state and returns the report it causes.
  function automatic mahf_pkg::entry_t filter_update(logic [1:0] op, logic [CH_W-1:0] ch,
                                                     logic [SMP_W-1:0] smp);
    mahf_pkg::entry_t rep;
    int s, half, quarter, diff;
    logic [31:0] prod, quo;
    logic [FILT_W-1:0] nv;
    logic taken;
    s = int'(smp);
    half = int'(step_sz) / 2;
    quarter = int'(step_sz) / 4;
    if (op == mahf_pkg::OP_SAMPLE) begin
      if (!chan_flag[ch] && ch >= first_ch && ch <= last_ch) begin
        diff = s - int'(chan_raw[ch]);
        if (diff < 0) diff = -diff;
        taken = 1'b0;
        nv = chan_filt[ch];
        if (s < int'(max_lvl) - half && s > int'(min_lvl) + half) begin
          if (diff >= half) begin
            prod = 32'(s - half) * 32'(mul_k);
            quo = quot_or_ones(prod, 32'(div_k));
            nv = quo[FILT_W-1:0] + 16'd1;
            taken = 1'b1;
          end
        end else if (diff >= quarter) begin
          quo = quot_or_ones(32'(smp), 32'(step_sz));
          nv = quo[FILT_W-1:0];
          taken = 1'b1;
        end
        if (taken) begin
          if (nv != chan_filt[ch]) chan_flag[ch] = 1'b1;
          chan_filt[ch] = nv;
          chan_raw[ch] = smp;
        end
      end
    end else if (op == mahf_pkg::OP_CLEAR) begin
      chan_flag[ch] = 1'b0;
    end
    rep.filt = chan_filt[ch];
    rep.raw = chan_raw[ch];
    rep.flag = chan_flag[ch];
    return rep;
  endfunction

  task automatic send_item(input logic [1:0] op, input logic [CH_W-1:0] ch,
                           input logic [SMP_W-1:0] smp);
    int gap;
    if ($urandom_range(0, 99) == 0) in_burst = !in_burst;
    gap = (in_burst || $urandom_range(0, 1)) ? 0 : idle_len();
    @(negedge clk);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= {6'b0, smp, ch};
    in_tuser <= op;
    do @(posedge clk); while (!in_tready);
    channel_reports.push_back(filter_update(op, ch, smp));
  endtask

  // Holds the input off until every report has come back and the block has settled.
  task automatic wait_drained();
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (channel_reports.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [11:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      mahf_pkg::CFG_MIN_VALUE: min_lvl = val;
      mahf_pkg::CFG_MAX_VALUE: max_lvl = val;
      mahf_pkg::CFG_NOM_STEP:  step_sz = val;
      mahf_pkg::CFG_SCALE_MUL: mul_k = val[MUL_W-1:0];
      mahf_pkg::CFG_SCALE_DIV: div_k = val;
      mahf_pkg::CFG_FIRST_CH:  first_ch = val[CH_W-1:0];
      mahf_pkg::CFG_LAST_CH:   last_ch = val[CH_W-1:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  always @(negedge clk) begin : ready_drive
    if (hold_cycles > 0) begin
      out_tready <= 1'b0;
      hold_cycles--;
    end else begin
      out_tready <= 1'b1;
      if (!out_burst && $urandom_range(0, 3) == 0) hold_cycles = idle_len();
    end
    if ($urandom_range(0, 99) == 0) out_burst = !out_burst;
  end

  always @(posedge clk) begin : report_check
    mahf_pkg::entry_t want, got;
    if (rst_n && out_tvalid === 1'b1 && out_tready) begin
      got = mahf_pkg::entry_t'(out_tdata[28:0]);
      if (channel_reports.size() == 0) begin
        fail_count++;
        if (fail_count <= MAX_REPORTED)
          $display("unexpected result transaction: %h", out_tdata);
      end else begin
        want = channel_reports.pop_front();
        if (out_tdata !== {3'b000, want}) begin
          fail_count++;
          if (fail_count <= MAX_REPORTED)
            $display({"mismatch: filtered exp %h got %h, raw exp %h got %h, ",
                      "flag exp %b got %b, pad %b"},
                     want.filt, got.filt, want.raw, got.raw, want.flag, got.flag,
                     out_tdata[31:29]);
        end
      end
    end
  end

  task automatic test_reset_state();
    send_item(mahf_pkg::OP_READ, 6'd0, 12'hFFF);
    send_item(OP_RSVD, 6'd63, 12'h000);
  endtask

  // Runs on the reset configuration: channels 16 to 34, step 32, scale 1/32.
  task automatic test_default_filtering();
    send_item(mahf_pkg::OP_SAMPLE, 6'd16, 12'd4095);
    send_item(mahf_pkg::OP_SAMPLE, 6'd16, 12'd0);      // ignored while the flag is set
    send_item(mahf_pkg::OP_CLEAR, 6'd16, 12'd0);
    send_item(mahf_pkg::OP_SAMPLE, 6'd16, 12'd4090);   // move below a quarter step
    send_item(mahf_pkg::OP_SAMPLE, 6'd16, 12'd2048);   // mid band
    send_item(mahf_pkg::OP_CLEAR, 6'd34, 12'd0);
    send_item(mahf_pkg::OP_SAMPLE, 6'd34, 12'd4095);
    send_item(mahf_pkg::OP_SAMPLE, 6'd35, 12'd1000);
    send_item(mahf_pkg::OP_SAMPLE, 6'd15, 12'd1000);
    send_item(mahf_pkg::OP_SAMPLE, 6'd20, 12'd10);     // accepted, same filtered value
  endtask

  task automatic test_zero_divisors();
    wait_drained();
    write_reg(mahf_pkg::CFG_NOM_STEP, 12'd0);
    write_reg(mahf_pkg::CFG_SCALE_DIV, 12'd0);
    send_item(mahf_pkg::OP_SAMPLE, 6'd17, 12'd0);
    send_item(mahf_pkg::OP_SAMPLE, 6'd18, 12'd100);
    send_item(mahf_pkg::OP_CLEAR, 6'd17, 12'd0);
    send_item(mahf_pkg::OP_SAMPLE, 6'd17, 12'd4095);
  endtask

  task automatic test_empty_range();
    wait_drained();
    write_reg(mahf_pkg::CFG_NOM_STEP, 12'd32);
    write_reg(mahf_pkg::CFG_FIRST_CH, 12'd40);
    write_reg(mahf_pkg::CFG_LAST_CH, 12'd39);
    send_item(mahf_pkg::OP_SAMPLE, 6'd39, 12'd3000);
    send_item(mahf_pkg::OP_SAMPLE, 6'd40, 12'd3000);
    wait_drained();
    write_reg(mahf_pkg::CFG_FIRST_CH, 12'd63);
    write_reg(mahf_pkg::CFG_LAST_CH, 12'd63);
    send_item(mahf_pkg::OP_SAMPLE, 6'd63, 12'd1234);
  endtask

  task automatic test_scale_extremes();
    wait_drained();
    write_reg(mahf_pkg::CFG_MIN_VALUE, 12'd0);
    write_reg(mahf_pkg::CFG_MAX_VALUE, 12'd4095);
    write_reg(mahf_pkg::CFG_NOM_STEP, 12'd1);
    write_reg(mahf_pkg::CFG_SCALE_MUL, 12'hFFF);       // only the low eight bits are kept
    write_reg(mahf_pkg::CFG_SCALE_DIV, 12'd1);
    write_reg(mahf_pkg::CFG_FIRST_CH, 12'd0);
    write_reg(mahf_pkg::CFG_LAST_CH, 12'd63);
    write_reg(CFG_UNUSED, 12'hABC);
    send_item(mahf_pkg::OP_SAMPLE, 6'd0, 12'd4094);    // product overflows sixteen bits
    send_item(mahf_pkg::OP_SAMPLE, 6'd63, 12'd4095);
    send_item(mahf_pkg::OP_SAMPLE, 6'd1, 12'd0);
    wait_drained();
    write_reg(mahf_pkg::CFG_MIN_VALUE, 12'd4095);
    write_reg(mahf_pkg::CFG_MAX_VALUE, 12'd0);
    send_item(mahf_pkg::OP_SAMPLE, 6'd2, 12'd2000);
    wait_drained();
    write_reg(mahf_pkg::CFG_MIN_VALUE, 12'd0);
    write_reg(mahf_pkg::CFG_MAX_VALUE, 12'd4095);
    write_reg(mahf_pkg::CFG_NOM_STEP, 12'd4095);
    send_item(mahf_pkg::OP_SAMPLE, 6'd3, 12'd1500);
    send_item(mahf_pkg::OP_SAMPLE, 6'd4, 12'd4095);
  endtask

  // Each phase loads a fresh configuration, then mixes samples near the
  // hysteresis thresholds with flag clears and reads.
  task automatic test_random_traffic();
    int phase, k, i, r, v, thr;
    logic [11:0] vals [7];
    logic [1:0] op;
    logic [CH_W-1:0] ch;
    for (phase = 0; phase < RAND_PHASES; phase++) begin
      wait_drained();
      if (phase == 0) begin
        vals = '{mahf_pkg::MIN_VALUE_RST, mahf_pkg::MAX_VALUE_RST,
                 mahf_pkg::NOM_STEP_RST, 12'(mahf_pkg::SCALE_MUL_RST),
                 mahf_pkg::SCALE_DIV_RST, 12'(mahf_pkg::FIRST_CH_RST),
                 12'(mahf_pkg::LAST_CH_RST)};
      end else begin
        r = $urandom_range(0, 9);
        vals[0] = (r < 3) ? 12'd0 : (r < 7) ? 12'($urandom_range(0, 1000))
                                            : 12'($urandom_range(0, 4095));
        r = $urandom_range(0, 9);
        vals[1] = (r < 3) ? 12'd4095 : (r < 7) ? 12'($urandom_range(3000, 4095))
                                               : 12'($urandom_range(0, 4095));
        r = $urandom_range(0, 19);
        vals[2] = (r == 0) ? 12'd0 : (r < 6) ? 12'($urandom_range(1, 8)) :
                  (r < 12) ? 12'($urandom_range(16, 64)) :
                  (r < 18) ? 12'($urandom_range(1, 4095)) : 12'd4095;
        r = $urandom_range(0, 9);
        vals[3] = (r == 0) ? 12'd1 : (r == 1) ? 12'd255 : 12'($urandom_range(0, 4095));
        r = $urandom_range(0, 19);
        vals[4] = (r == 0) ? 12'd0 : (r < 3) ? 12'd1 : (r < 11) ? 12'($urandom_range(1, 64))
                                                               : 12'($urandom_range(1, 4095));
        r = $urandom_range(0, 19);
        if (r < 4) begin
          vals[5] = 12'd0;
          vals[6] = 12'd63;
        end else begin
          vals[5] = 12'($urandom_range(0, 63));
          vals[6] = 12'($urandom_range(0, 63));
          if (r < 17 && vals[5] > vals[6]) begin
            v = vals[5];
            vals[5] = vals[6];
            vals[6] = 12'(v);
          end
        end
      end
      for (i = 0; i < 7; i++) write_reg(3'(i), vals[i]);

      for (k = 0; k < RAND_PER_PHASE; k++) begin
        if (phase == 3 && k == RAND_PER_PHASE / 2) wait_drained();
        r = $urandom_range(0, 99);
        if (first_ch <= last_ch && r < 80) ch = CH_W'($urandom_range(first_ch, last_ch));
        else ch = CH_W'($urandom_range(0, 63));
        r = $urandom_range(0, 99);
        if (r < 55)
          op = (chan_flag[ch] && $urandom_range(0, 1)) ? mahf_pkg::OP_CLEAR
                                                       : mahf_pkg::OP_SAMPLE;
        else if (r < 80) op = mahf_pkg::OP_CLEAR;
        else if (r < 93) op = mahf_pkg::OP_READ;
        else op = OP_RSVD;
        r = $urandom_range(0, 9);
        if (r < 4) begin
          v = int'($urandom_range(0, 4095));
        end else if (r < 8) begin
          // Land just either side of the half or quarter step threshold.
          thr = $urandom_range(0, 1) ? int'(step_sz) / 2 : int'(step_sz) / 4;
          v = thr + int'($urandom_range(0, 2)) - 1;
          if ($urandom_range(0, 1)) v = -v;
          v = v + int'(chan_raw[ch]);
        end else if (r == 8) begin
          thr = int'(step_sz) / 2;
          v = ($urandom_range(0, 1) ? int'(min_lvl) + thr : int'(max_lvl) - thr)
              + int'($urandom_range(0, 2)) - 1;
        end else begin
          v = $urandom_range(0, 1) ? 0 : 4095;
        end
        if (v < 0) v = 0;
        if (v > 4095) v = 4095;
        send_item(op, ch, 12'(v));
      end
    end
  endtask

  initial begin
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_reset_state();
    test_default_filtering();
    test_zero_divisors();
    test_empty_range();
    test_scale_extremes();
    test_random_traffic();

    wait_drained();
    if (fail_count == 0)
      $display("Regression PASS");
    else
      $display("Regression FAIL");
    $finish;
  end

endmodule
